// File: hdl/bdg_pkg.sv
`timescale 1ns / 1ps
package bdg_pkg;

  localparam int MAX_CELL_WIDTH = 255;
  localparam logic [20:0] BOX_BASE = 21'h02500;
  localparam int BOX_COUNT = 160;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  localparam logic [15:0] NOCTR  = 16'h0002;
  localparam logic [15:0] ROUND  = 16'h0004;
  localparam logic [15:0] BLOCK  = 16'h0008;
  localparam logic [15:0] A_U    = 16'h0010;
  localparam logic [15:0] A_D    = 16'h0020;
  localparam logic [15:0] A_L    = 16'h0040;
  localparam logic [15:0] A_R    = 16'h0080;
  localparam logic [15:0] B_U    = 16'h0100;
  localparam logic [15:0] B_D    = 16'h0200;
  localparam logic [15:0] B_L    = 16'h0400;
  localparam logic [15:0] B_R    = 16'h0800;
  localparam logic [15:0] Q_UL   = BLOCK | 16'h0010;
  localparam logic [15:0] Q_UR   = BLOCK | 16'h0020;
  localparam logic [15:0] Q_LL   = BLOCK | 16'h0040;
  localparam logic [15:0] Q_LR   = BLOCK | 16'h0080;
  localparam logic [15:0] VBAR   = BLOCK | 16'h0100;
  localparam logic [15:0] VBAR_R = BLOCK | 16'h0200;
  localparam logic [15:0] HBAR   = BLOCK | 16'h0400;
  localparam logic [15:0] HBAR_R = BLOCK | 16'h0800;
  localparam logic [15:0] DIAG_L = BLOCK | 16'h1000;
  localparam logic [15:0] DIAG_R = BLOCK | 16'h2000;
  localparam logic [15:0] DOT_A  = 16'h4000;
  localparam logic [15:0] DOT_B  = 16'h8000;

  localparam logic [15:0] SHAPE_ROM [BOX_COUNT] = '{
    A_L|A_R, A_L|B_L|A_R|B_R, A_U|A_D, A_U|B_U|A_D|B_D,
    A_L|A_R|DOT_A, A_L|B_L|A_R|B_R|DOT_A, A_U|A_D|DOT_A, A_U|B_U|A_D|B_D|DOT_A,
    A_L|A_R|DOT_B, A_L|B_L|A_R|B_R|DOT_B, A_U|A_D|DOT_B, A_U|B_U|A_D|B_D|DOT_B,
    A_D|A_R, A_D|A_R|B_R, A_D|B_D|A_R, A_D|B_D|A_R|B_R,
    A_D|A_L, A_D|A_L|B_L, A_D|B_D|A_L, A_D|B_D|A_L|B_L,
    A_U|A_R, A_U|A_R|B_R, A_U|B_U|A_R, A_U|B_U|A_R|B_R,
    A_U|A_L, A_U|A_L|B_L, A_U|B_U|A_L, A_U|B_U|A_L|B_L,
    A_U|A_D|A_R, A_U|A_D|A_R|B_R, A_U|B_U|A_D|A_R, A_U|A_D|B_D|A_R,
    A_U|B_U|A_D|B_D|A_R, A_U|B_U|A_D|A_R|B_R, A_U|A_D|B_D|A_R|B_R,
    A_U|B_U|A_D|B_D|A_R|B_R,
    A_U|A_D|A_L, A_U|A_D|A_L|B_L, A_U|B_U|A_D|A_L, A_U|A_D|B_D|A_L,
    A_U|B_U|A_D|B_D|A_L, A_U|B_U|A_D|A_L|B_L, A_U|A_D|B_D|A_L|B_L,
    A_U|B_U|A_D|B_D|A_L|B_L,
    A_L|A_D|A_R, A_L|B_L|A_D|A_R, A_L|A_D|A_R|B_R, A_L|B_L|A_D|A_R|B_R,
    A_L|A_D|B_D|A_R, A_L|B_L|A_D|B_D|A_R, A_L|A_D|B_D|A_R|B_R, A_L|B_L|A_D|B_D|A_R|B_R,
    A_L|A_U|A_R, A_L|B_L|A_U|A_R, A_L|A_U|A_R|B_R, A_L|B_L|A_U|A_R|B_R,
    A_L|A_U|B_U|A_R, A_L|B_L|A_U|B_U|A_R, A_L|A_U|B_U|A_R|B_R, A_L|B_L|A_U|B_U|A_R|B_R,
    A_L|A_R|A_U|A_D, A_L|B_L|A_R|A_U|A_D, A_L|A_R|B_R|A_U|A_D, A_L|B_L|A_R|B_R|A_U|A_D,
    A_L|A_R|A_U|B_U|A_D, A_L|A_R|A_U|A_D|B_D, A_L|A_R|A_U|B_U|A_D|B_D,
    A_L|B_L|A_R|A_U|B_U|A_D,
    A_L|A_R|B_R|A_U|B_U|A_D, A_L|B_L|A_R|A_U|A_D|B_D, A_L|A_R|B_R|A_U|A_D|B_D,
    A_L|B_L|A_R|B_R|A_U|B_U|A_D,
    A_L|B_L|A_R|B_R|A_U|A_D|B_D, A_L|B_L|A_R|A_U|B_U|A_D|B_D,
    A_L|A_R|B_R|A_U|B_U|A_D|B_D, A_L|B_L|A_R|B_R|A_U|B_U|A_D|B_D,
    A_L|A_R|NOCTR, A_L|B_L|A_R|B_R|NOCTR, A_U|A_D|NOCTR, A_U|B_U|A_D|B_D|NOCTR,
    B_L|B_R, B_U|B_D, A_D|B_R, B_D|A_R,
    B_D|B_R, A_D|B_L, B_D|A_L, B_D|B_L,
    A_U|B_R, B_U|A_R, B_U|B_R, A_U|B_L,
    B_U|A_L, B_U|B_L, A_U|A_D|B_R, B_U|B_D|A_R,
    B_U|B_D|B_R, A_U|A_D|B_L, B_U|B_D|A_L, B_U|B_D|B_L,
    B_L|B_R|A_D, A_L|A_R|B_D, B_L|B_R|B_D, B_L|B_R|A_U,
    A_L|A_R|B_U, B_L|B_R|B_U, A_U|A_D|B_R|B_L, B_U|B_D|A_R|A_L,
    B_U|B_D|B_R|B_L, A_R|A_D|ROUND|NOCTR, A_L|A_D|ROUND|NOCTR, A_U|A_L|ROUND|NOCTR,
    A_U|A_R|ROUND|NOCTR, DIAG_R, DIAG_L, DIAG_R|DIAG_L,
    A_L, A_U, A_R, A_D,
    B_L, A_R, B_U, B_D,
    A_L|B_R, A_U|B_D, B_L|A_R, B_U|A_D,
    Q_UL|Q_UR, HBAR, HBAR|16'd1, HBAR|16'd2,
    HBAR|16'd3, HBAR|16'd4, HBAR|16'd5, HBAR|16'd6,
    HBAR|16'd7, VBAR|16'd6, VBAR|16'd5, VBAR|16'd4,
    VBAR|16'd3, VBAR|16'd2, VBAR|16'd1, VBAR,
    Q_UR|Q_LR, BLOCK|DOT_A, BLOCK|DOT_B, DOT_A|HBAR|16'd7,
    HBAR_R, VBAR_R, Q_LL, Q_LR,
    Q_UL, Q_UL|Q_LR|Q_LL, Q_UL|Q_LR, Q_UL|Q_UR|Q_LL,
    Q_UL|Q_UR|Q_LR, Q_UR, Q_UR|Q_LL, Q_UR|Q_LL|Q_LR
  };

  typedef logic signed [11:0] crd_t;
  typedef logic signed [2:0] mul_t;

  typedef struct packed {
    logic        box;
    logic        inr;
    logic [15:0] d;
    logic [7:0]  px;
    logic [8:0]  py;
    logic [7:0]  w;
    logic [8:0]  h;
  } dec_t;

  typedef struct packed {
    logic        box;
    logic        inr;
    logic [15:0] d;
    logic [7:0]  px;
    logic [8:0]  py;
    logic [7:0]  w;
    logic [8:0]  h;
    logic [6:0]  cw;
    logic [7:0]  ch;
    logic [4:0]  lw;
    crd_t        x0;
    crd_t        y0;
    logic [4:0]  half;
    logic [10:0] wf;
    logic [10:0] wr;
    logic [11:0] hf;
    logic [11:0] hr;
    logic [16:0] wpy;
    logic [16:0] pxh;
    logic [16:0] kh;
    logic [9:0]  n;
    logic [19:0] prod;
  } geo_t;

  function automatic logic hit(input crd_t px, input crd_t py, input crd_t xs,
                               input crd_t ys, input crd_t xe, input crd_t ye);
    return (xs < xe) && (ys < ye) && (px >= xs) && (px < xe) && (py >= ys) && (py < ye);
  endfunction

  function automatic crd_t lwm(input logic [4:0] lw, input mul_t m);
    crd_t l;
    crd_t r;
    l = crd_t'({7'b0, lw});
    unique case (m)
      -3'sd1:  r = -l;
      3'sd1:   r = l;
      3'sd2:   r = l <<< 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic mul_t bmax(input logic b, input logic c);
    return c ? 3'sd2 : (b ? 3'sd1 : 3'sd0);
  endfunction

endpackage

// File: hdl/bdg_decode.sv
`timescale 1ns / 1ps
module bdg_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [20:0]       codepoint,
  input  logic [7:0]        pixel_x,
  input  logic [8:0]        pixel_y,
  input  logic [7:0]        cell_w,
  input  logic [8:0]        cell_h,
  output logic              a_valid,
  output bdg_pkg::dec_t     a
);

  logic [20:0]   ofs;
  bdg_pkg::dec_t a_next;

  always_comb begin
    ofs = codepoint - bdg_pkg::BOX_BASE;
    a_next.box = (codepoint >= bdg_pkg::BOX_BASE) &&
                 (codepoint < bdg_pkg::BOX_BASE + 21'(bdg_pkg::BOX_COUNT));
    a_next.d = a_next.box ? bdg_pkg::SHAPE_ROM[ofs[7:0]] : '0;
    a_next.inr = (pixel_x < cell_w) && (pixel_y < cell_h);
    a_next.px = pixel_x;
    a_next.py = pixel_y;
    a_next.w = cell_w;
    a_next.h = cell_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_next;
    end
  end

endmodule

// File: hdl/bdg_geom.sv
`timescale 1ns / 1ps
module bdg_geom (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              a_valid,
  input  bdg_pkg::dec_t     a,
  output logic              g_valid,
  output bdg_pkg::geo_t     g
);

  bdg_pkg::geo_t g_next;
  logic [2:0]    frac;
  logic [2:0]    frac7;
  logic [7:0]    k;
  logic [4:0]    lw;
  logic [4:0]    lw2;
  logic [8:0]    nsel;

  always_comb begin
    frac = a.d[2:0];
    frac7 = 3'd7 - frac;
    k = a.w - 8'd1 - a.px;
    lw = (a.w[7:3] == 5'd0) ? 5'd1 : a.w[7:3];
    lw2 = (lw[4:1] == 4'd0) ? 5'd1 : {1'b0, lw[4:1]};
    nsel = a.d[4] ? a.h : {1'b0, a.w};
    g_next.box = a.box;
    g_next.inr = a.inr;
    g_next.d = a.d;
    g_next.px = a.px;
    g_next.py = a.py;
    g_next.w = a.w;
    g_next.h = a.h;
    g_next.cw = a.w[7:1];
    g_next.ch = a.h[8:1];
    g_next.lw = lw;
    g_next.x0 = bdg_pkg::crd_t'({5'b0, a.w[7:1]}) - bdg_pkg::crd_t'({7'b0, lw})
              + bdg_pkg::crd_t'({7'b0, lw2});
    g_next.y0 = bdg_pkg::crd_t'({4'b0, a.h[8:1]}) - bdg_pkg::crd_t'({7'b0, lw})
              + bdg_pkg::crd_t'({7'b0, lw2});
    g_next.half = 5'((6'({1'b0, lw}) + 6'd1) >> 1);
    g_next.wf = 11'(a.w) * 11'(frac);
    g_next.wr = 11'(a.w) * 11'(frac7);
    g_next.hf = 12'(a.h) * 12'(frac);
    g_next.hr = 12'(a.h) * 12'(frac7);
    g_next.wpy = 17'(a.w) * 17'(a.py);
    g_next.pxh = 17'(a.px) * 17'(a.h);
    g_next.kh = 17'(k) * 17'(a.h);
    g_next.n = 10'(nsel) + 10'd1 + 10'(a.d[15]);
    g_next.prod = 20'(g_next.n) * 20'd683;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g <= g_next;
    end
  end

endmodule

// File: hdl/bdg_raster.sv
`timescale 1ns / 1ps
module bdg_raster (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              g_valid,
  input  bdg_pkg::geo_t     g,
  output logic              out_valid,
  output logic              is_box,
  output logic              lit
);

  typedef bdg_pkg::crd_t crd_t;
  typedef bdg_pkg::mul_t mul_t;

  crd_t px, py, w, h, cw, ch, x0, y0, lw, lw2x, half;
  crd_t s1, s2, s3;
  logic [7:0] sdiv;
  logic [7:0] step;
  logic [7:0] dx;
  logic nc, rc, tl, bl, ll, rl, td, bd, ld, rd, da, db, none_v, none_h;
  mul_t m1, m2, m3, m4, m5, m6;
  logic blk, blk_dot, line_on, line_off, diag_l, diag_r, pix;

  always_comb begin
    px = crd_t'({4'b0, g.px});
    py = crd_t'({3'b0, g.py});
    w = crd_t'({4'b0, g.w});
    h = crd_t'({3'b0, g.h});
    cw = crd_t'({5'b0, g.cw});
    ch = crd_t'({4'b0, g.ch});
    x0 = g.x0;
    y0 = g.y0;
    lw = crd_t'({7'b0, g.lw});
    lw2x = lw <<< 1;
    half = crd_t'({7'b0, g.half});
    nc = g.d[1];
    rc = g.d[2];
    tl = g.d[4];
    bl = g.d[5];
    ll = g.d[6];
    rl = g.d[7];
    td = g.d[8];
    bd = g.d[9];
    ld = g.d[10];
    rd = g.d[11];
    da = g.d[14];
    db = g.d[15];
    none_v = !(tl | td | bl | bd);
    none_h = !(ll | ld | rl | rd);

    diag_l = g.d[12] && (g.pxh <= g.wpy) && (18'(g.wpy) < 18'(g.pxh) + 18'(g.h));
    diag_r = g.d[13] && (g.kh <= g.wpy) && (18'(g.wpy) < 18'(g.kh) + 18'(g.h));
    blk = (g.d[4] && bdg_pkg::hit(px, py, '0, '0, cw, ch))
        || (g.d[5] && bdg_pkg::hit(px, py, cw, '0, w, ch))
        || (g.d[6] && bdg_pkg::hit(px, py, '0, ch, cw, h))
        || (g.d[7] && bdg_pkg::hit(px, py, cw, ch, w, h))
        || (g.d[10] && bdg_pkg::hit(px, py, '0, crd_t'({3'b0, g.hr[11:3]}), w, h))
        || (g.d[8] && bdg_pkg::hit(px, py, '0, '0, crd_t'({4'b0, g.wf[10:3]}), h))
        || (g.d[11] && bdg_pkg::hit(px, py, '0, '0, w, crd_t'({3'b0, g.hf[11:3]})))
        || (g.d[9] && bdg_pkg::hit(px, py, crd_t'({4'b0, g.wr[10:3]}), '0, w, h))
        || diag_l || diag_r;
    if (da) begin
      dx = g.px - {6'b0, g.py[1], 1'b0};
      blk_dot = !g.py[0] && (g.px >= {6'b0, g.py[1], 1'b0}) && (dx[1:0] == 2'd0);
    end else begin
      dx = g.px - {7'b0, g.py[0]};
      blk_dot = db && (g.px >= {7'b0, g.py[0]}) && !dx[0];
    end

    m1 = nc ? -3'sd1 : mul_t'({2'b0, !(td && bd && !tl)});
    m2 = nc ? -3'sd1 : mul_t'({2'b0, !(ld && rd && !ll)});
    m3 = nc ? -3'sd1 : ((!(td | tl) ? bdg_pkg::bmax(bl, bd) : 3'sd0)
                        + mul_t'({2'b0, none_v}));
    m4 = nc ? -3'sd1 : ((!(bd | bl) ? bdg_pkg::bmax(tl, td) : 3'sd0)
                        + mul_t'({2'b0, none_v}));
    m5 = nc ? -3'sd1 : ((!(ld | ll) ? bdg_pkg::bmax(rl, rd) : 3'sd0)
                        + mul_t'({2'b0, none_h}));
    m6 = nc ? -3'sd1 : ((!(rd | rl) ? bdg_pkg::bmax(ll, ld) : 3'sd0)
                        + mul_t'({2'b0, none_h}));

    line_on = (rc && bdg_pkg::hit(px, py,
                 x0 + bdg_pkg::lwm(g.lw, rl ? 3'sd1 : -3'sd1),
                 y0 + bdg_pkg::lwm(g.lw, bl ? 3'sd1 : -3'sd1),
                 x0 + bdg_pkg::lwm(g.lw, rl ? 3'sd2 : 3'sd0),
                 y0 + bdg_pkg::lwm(g.lw, bl ? 3'sd2 : 3'sd0)))
      || (ll && bdg_pkg::hit(px, py, '0, y0, x0 + bdg_pkg::lwm(g.lw, m1), y0 + lw))
      || (rl && bdg_pkg::hit(px, py, x0 + bdg_pkg::lwm(g.lw, 3'sd1 - m1), y0, w, y0 + lw))
      || (tl && bdg_pkg::hit(px, py, x0, '0, x0 + lw, y0 + bdg_pkg::lwm(g.lw, m2)))
      || (bl && bdg_pkg::hit(px, py, x0, y0 + bdg_pkg::lwm(g.lw, 3'sd1 - m2), x0 + lw, h))
      || (ld && bdg_pkg::hit(px, py, '0, y0 - lw, x0 + bdg_pkg::lwm(g.lw, m3), y0))
      || (rd && bdg_pkg::hit(px, py, x0 + bdg_pkg::lwm(g.lw, 3'sd1 - m3), y0 - lw, w, y0))
      || (ld && bdg_pkg::hit(px, py, '0, y0 + lw, x0 + bdg_pkg::lwm(g.lw, m4), y0 + lw2x))
      || (rd && bdg_pkg::hit(px, py, x0 + bdg_pkg::lwm(g.lw, 3'sd1 - m4), y0 + lw, w,
                             y0 + lw2x))
      || (td && bdg_pkg::hit(px, py, x0 - lw, '0, x0, y0 + bdg_pkg::lwm(g.lw, m5)))
      || (bd && bdg_pkg::hit(px, py, x0 - lw, y0 + bdg_pkg::lwm(g.lw, 3'sd1 - m5), x0, h))
      || (td && bdg_pkg::hit(px, py, x0 + lw, '0, x0 + lw2x, y0 + bdg_pkg::lwm(g.lw, m6)))
      || (bd && bdg_pkg::hit(px, py, x0 + lw, y0 + bdg_pkg::lwm(g.lw, 3'sd1 - m6),
                             x0 + lw2x, h));

    sdiv = db ? g.n[9:2] : g.prod[18:11];
    step = (sdiv == 8'd0) ? 8'd1 : sdiv;
    s1 = crd_t'({4'b0, step});
    s2 = s1 <<< 1;
    s3 = s1 + s2;
    if (tl) begin
      line_off = (da | db) && (bdg_pkg::hit(px, py, x0 - lw, s1 - half, x0 + lw2x, s1 + half)
               || bdg_pkg::hit(px, py, x0 - lw, s2 - half, x0 + lw2x, s2 + half)
               || (db && bdg_pkg::hit(px, py, x0 - lw, s3 - half, x0 + lw2x, s3 + half)));
    end else begin
      line_off = (da | db) && (bdg_pkg::hit(px, py, s1 - half, y0 - lw, s1 + half, y0 + lw2x)
               || bdg_pkg::hit(px, py, s2 - half, y0 - lw, s2 + half, y0 + lw2x)
               || (db && bdg_pkg::hit(px, py, s3 - half, y0 - lw, s3 + half, y0 + lw2x)));
    end

    if (g.d[3]) begin
      pix = blk_dot ? !g.d[10] : blk;
    end else begin
      pix = line_on && !line_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_box <= g.box;
      lit <= g.box && g.inr && pix;
    end
  end

endmodule

// File: hdl/box_drawing_glyph_pixel_top.sv
`timescale 1ns / 1ps
// Box-drawing and block-element pixel generator (U+2500..U+259F). Each request
// carries a codepoint and one pixel coordinate; the result tells whether the
// codepoint is in range and whether that pixel is lit in a cell of cell_width
// columns by cell_height + cell_depth rows. A request is taken every cycle
// while results are taken; it passes the ROM lookup, geometry and multiplies,
// and rectangle tests into the output register. A held result stalls
// the whole pipeline and the input. Write the cell size registers only while idle.
module box_drawing_glyph_pixel_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [20:0] codepoint,
  input  logic [7:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_box,
  output logic        lit,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]    cell_width;
  logic [7:0]    cell_height;
  logic [7:0]    cell_depth;
  logic [7:0]    cell_w;
  logic [8:0]    cell_h;
  logic          en;
  logic          a_valid;
  logic          g_valid;
  bdg_pkg::dec_t a;
  bdg_pkg::geo_t g;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= 8'd8;
      cell_height <= 8'd12;
      cell_depth <= 8'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdg_pkg::REG_WIDTH:  cell_width <= cfg_data;
        bdg_pkg::REG_HEIGHT: cell_height <= cfg_data;
        bdg_pkg::REG_DEPTH:  cell_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cell_w = (10'(cell_width) > 10'(bdg_pkg::MAX_CELL_WIDTH))
           ? 8'(bdg_pkg::MAX_CELL_WIDTH) : cell_width;
    cell_h = 9'(cell_height) + 9'(cell_depth);
    en = !out_valid || out_ready;
    in_ready = en;
  end

  bdg_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .codepoint (codepoint),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .cell_w    (cell_w),
    .cell_h    (cell_h),
    .a_valid   (a_valid),
    .a         (a)
  );

  bdg_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (a_valid),
    .a       (a),
    .g_valid (g_valid),
    .g       (g)
  );

  bdg_raster u_raster (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .g_valid   (g_valid),
    .g         (g),
    .out_valid (out_valid),
    .is_box    (is_box),
    .lit       (lit)
  );

endmodule
